// ===== hw/rtl/cau_pkg.sv =====
// Shared types, constants and helper functions of the complex arithmetic unit.
// Used by the channel interfaces and every module of the block; no dependencies.
`timescale 1ns / 1ps

package cau_pkg;

    // Operand format: signed fixed point with FRAC_BITS fraction bits.
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int FUNC_W     = 3;

    // Derived widths of the datapath.
    localparam int SUM_W  = DATA_WIDTH + 1;
    localparam int PROD_W = 2 * DATA_WIDTH;
    localparam int MAG_W  = 2 * DATA_WIDTH + 1;
    localparam int DEN_W  = 2 * DATA_WIDTH;
    localparam int REM_W  = 3 * DATA_WIDTH + FRAC_BITS + 1;

    // Saturation limits held as magnitudes.
    localparam logic [MAG_W-1:0] SAT_POS = (MAG_W'(1) << (DATA_WIDTH - 1)) - MAG_W'(1);
    localparam logic [MAG_W-1:0] SAT_NEG = MAG_W'(1) << (DATA_WIDTH - 1);

    // Operation codes.
    typedef enum logic [FUNC_W-1:0] {
        FN_ADD  = 3'd0,
        FN_SUB  = 3'd1,
        FN_MUL  = 3'd2,
        FN_DIV  = 3'd3,
        FN_CONJ = 3'd4
    } func_t;

    // Saturated word together with its overflow mark.
    typedef struct packed {
        logic                  ovf;
        logic [DATA_WIDTH-1:0] val;
    } sat_t;

    // Payload of one item as it moves through the divider stages.
    typedef struct packed {
        logic                  is_div;
        logic                  dz;
        logic                  eq;
        logic                  gt;
        logic                  neg_re;
        logic                  neg_im;
        logic                  big_re;
        logic                  big_im;
        logic                  pre_ovf;
        logic [DATA_WIDTH-1:0] pre_re;
        logic [DATA_WIDTH-1:0] pre_im;
        logic [REM_W-1:0]      rem_re;
        logic [REM_W-1:0]      rem_im;
        logic [REM_W-1:0]      dvs;
        logic [DATA_WIDTH-1:0] q_re;
        logic [DATA_WIDTH-1:0] q_im;
    } stage_t;

    // Magnitude of a signed value.
    function automatic logic [MAG_W-1:0] abs_mag(input logic signed [MAG_W-1:0] v);
        return v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
    endfunction

    // Clamp a sign and magnitude pair to the signed output word.
    function automatic sat_t saturate(input logic neg, input logic [MAG_W-1:0] mag);
        sat_t             r;
        logic [MAG_W-1:0] lim;
        logic [MAG_W-1:0] m;
        lim   = neg ? SAT_NEG : SAT_POS;
        m     = mag;
        r.ovf = (mag > lim);
        if (r.ovf)
        begin
            m = lim;
        end
        r.val = neg ? (DATA_WIDTH'(0) - m[DATA_WIDTH-1:0]) : m[DATA_WIDTH-1:0];
        return r;
    endfunction

endpackage

// ===== hw/rtl/cau_in_if.sv =====
// Request channel of the complex arithmetic unit: operation code and two operands.
// Depends on cau_pkg.
`timescale 1ns / 1ps

interface cau_in_if;
    import cau_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [FUNC_W-1:0]            func;
    logic signed [DATA_WIDTH-1:0] a_re;
    logic signed [DATA_WIDTH-1:0] a_im;
    logic signed [DATA_WIDTH-1:0] b_re;
    logic signed [DATA_WIDTH-1:0] b_im;

    modport source (output valid, func, a_re, a_im, b_re, b_im, input ready);
    modport sink   (input valid, func, a_re, a_im, b_re, b_im, output ready);
endinterface

// ===== hw/rtl/cau_out_if.sv =====
// Response channel of the complex arithmetic unit: result and status flags.
// Depends on cau_pkg.
`timescale 1ns / 1ps

interface cau_out_if;
    import cau_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] res_re;
    logic signed [DATA_WIDTH-1:0] res_im;
    logic                         div_zero;
    logic                         overflow;
    logic                         equal;
    logic                         real_greater;

    modport source (output valid, res_re, res_im, div_zero, overflow, equal, real_greater,
                    input ready);
    modport sink   (input valid, res_re, res_im, div_zero, overflow, equal, real_greater,
                    output ready);
endinterface

// ===== hw/rtl/complex_arithmetic_unit.sv =====
// Complex arithmetic unit on signed fixed-point operands.
// Channels: req (cau_in_if) carries func and the operands a and b; rsp (cau_out_if)
// carries the saturated result and the div_zero, overflow, equal and real_greater flags.
// An item is taken when valid and ready are both high; every request gives one response.
// rsp.valid and the result pass through DATA_WIDTH + 4 register stages: three front stages
// for products and sums, one divider stage per quotient bit, one output register. Every
// operation takes the same path, so order is always kept.
// Throughput is one item per cycle for any mix of operations while rsp is not stalled.
// When rsp is stalled the whole pipeline holds and req.ready falls in the same cycle;
// nothing is dropped or repeated. Reset clears the valid bits only; the data registers are
// not reset, and the block is ready in the first cycle after reset is released.
// Depends on cau_pkg, cau_in_if, cau_out_if, cau_front and cau_div_stage.
`timescale 1ns / 1ps

module complex_arithmetic_unit (
    input  logic      clk,
    input  logic      rst_n,
    cau_in_if.sink    req,
    cau_out_if.source rsp
);
    import cau_pkg::*;

    logic   en;
    logic   stg_valid [DATA_WIDTH+1];
    stage_t stg_data  [DATA_WIDTH+1];

    logic                  out_valid_reg;
    logic [DATA_WIDTH-1:0] res_re_reg, res_im_reg;
    logic                  div_zero_reg, overflow_reg, equal_reg, greater_reg;

    sat_t                  fin_re, fin_im;
    logic [DATA_WIDTH-1:0] res_re_next, res_im_next;
    logic                  overflow_next;

    // The pipeline moves whenever the output register is free or being emptied.
    assign en        = !out_valid_reg || rsp.ready;
    assign req.ready = en;

    cau_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (req.valid),
        .func      (req.func),
        .a_re      (req.a_re),
        .a_im      (req.a_im),
        .b_re      (req.b_re),
        .b_im      (req.b_im),
        .out_valid (stg_valid[0]),
        .out_data  (stg_data[0])
    );

    // One division step per quotient bit.
    for (genvar k = 0; k < DATA_WIDTH; k++)
    begin : g_div
        cau_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (stg_valid[k]),
            .in_data   (stg_data[k]),
            .out_valid (stg_valid[k+1]),
            .out_data  (stg_data[k+1])
        );
    end

    // Pick the result for the operation and saturate the quotients.
    always_comb
    begin
        fin_re        = saturate(stg_data[DATA_WIDTH].neg_re, MAG_W'(stg_data[DATA_WIDTH].q_re));
        fin_im        = saturate(stg_data[DATA_WIDTH].neg_im, MAG_W'(stg_data[DATA_WIDTH].q_im));
        res_re_next   = stg_data[DATA_WIDTH].pre_re;
        res_im_next   = stg_data[DATA_WIDTH].pre_im;
        overflow_next = stg_data[DATA_WIDTH].pre_ovf;
        if (stg_data[DATA_WIDTH].is_div)
        begin
            if (stg_data[DATA_WIDTH].dz)
            begin
                res_re_next   = '0;
                res_im_next   = '0;
                overflow_next = 1'b0;
            end
            else
            begin
                if (stg_data[DATA_WIDTH].big_re)
                begin
                    fin_re = saturate(stg_data[DATA_WIDTH].neg_re, '1);
                end
                if (stg_data[DATA_WIDTH].big_im)
                begin
                    fin_im = saturate(stg_data[DATA_WIDTH].neg_im, '1);
                end
                res_re_next   = fin_re.val;
                res_im_next   = fin_im.val;
                overflow_next = fin_re.ovf | fin_im.ovf;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= stg_valid[DATA_WIDTH];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_re_reg   <= res_re_next;
            res_im_reg   <= res_im_next;
            div_zero_reg <= stg_data[DATA_WIDTH].dz;
            overflow_reg <= overflow_next;
            equal_reg    <= stg_data[DATA_WIDTH].eq;
            greater_reg  <= stg_data[DATA_WIDTH].gt;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.res_re       = res_re_reg;
    assign rsp.res_im       = res_im_reg;
    assign rsp.div_zero     = div_zero_reg;
    assign rsp.overflow     = overflow_reg;
    assign rsp.equal        = equal_reg;
    assign rsp.real_greater = greater_reg;

    // A zero divisor gives a plain zero result with no overflow.
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && div_zero_reg) |-> (!overflow_reg && res_re_reg == '0
                                             && res_im_reg == '0))
        else $error("div_zero item with non-zero result or overflow");

    // Equal operands cannot have a greater real part.
    a_eq_gt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(equal_reg && greater_reg))
        else $error("equal and real_greater both set");

    // Overflow means at least one part sits at a saturation limit.
    a_ovf_lim: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && overflow_reg) |->
            (res_re_reg == SAT_POS[DATA_WIDTH-1:0] || res_re_reg == SAT_NEG[DATA_WIDTH-1:0]
             || res_im_reg == SAT_POS[DATA_WIDTH-1:0]
             || res_im_reg == SAT_NEG[DATA_WIDTH-1:0]))
        else $error("overflow set with result off the limits");

    // A stalled output freezes the last divider stage.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |=>
            ($stable(stg_valid[DATA_WIDTH]) && $stable(stg_data[DATA_WIDTH])))
        else $error("pipeline moved while output stalled");

endmodule

// ===== hw/rtl/cau_front.sv =====
// Front end: products, sums and sign/magnitude preparation in three stages.
// Depends on cau_pkg; feeds the divider stages.
`timescale 1ns / 1ps

module cau_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic [cau_pkg::FUNC_W-1:0]           func,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] a_re,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] a_im,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] b_re,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] b_im,
    output logic                                 out_valid,
    output cau_pkg::stage_t                      out_data
);
    import cau_pkg::*;

    // Stage 1 registers: products and compares.
    logic                         v1_reg;
    logic [FUNC_W-1:0]            func1_reg;
    logic signed [DATA_WIDTH-1:0] a_re1_reg, a_im1_reg, b_re1_reg, b_im1_reg;
    logic signed [PROD_W-1:0]     p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [PROD_W-1:0]     p_br_reg, p_bi_reg;
    logic                         eq1_reg, gt1_reg;

    // Stage 2 registers: combined sums.
    logic                         v2_reg;
    logic [FUNC_W-1:0]            func2_reg;
    logic                         eq2_reg, gt2_reg;
    logic signed [MAG_W-1:0]      m_re_reg, m_im_reg, n_re_reg, n_im_reg;
    logic [DEN_W-1:0]             den_reg;
    logic signed [SUM_W-1:0]      s_re_reg, s_im_reg;
    logic signed [SUM_W-1:0]      s_re_next, s_im_next;

    // Stage 3 registers: item ready for the divider.
    logic                         v3_reg;
    stage_t                       st3_reg;
    stage_t                       st3_next;

    // Valid bits advance with the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Stage 1: six signed multiplications and the operand compares.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            func1_reg <= func;
            a_re1_reg <= a_re;
            a_im1_reg <= a_im;
            b_re1_reg <= b_re;
            b_im1_reg <= b_im;
            p_rr_reg  <= PROD_W'(a_re) * PROD_W'(b_re);
            p_ii_reg  <= PROD_W'(a_im) * PROD_W'(b_im);
            p_ri_reg  <= PROD_W'(a_re) * PROD_W'(b_im);
            p_ir_reg  <= PROD_W'(a_im) * PROD_W'(b_re);
            p_br_reg  <= PROD_W'(b_re) * PROD_W'(b_re);
            p_bi_reg  <= PROD_W'(b_im) * PROD_W'(b_im);
            eq1_reg   <= (a_re == b_re) && (a_im == b_im);
            gt1_reg   <= (a_re > b_re);
        end
    end

    // Add, subtract and conjugate are exact in one extra bit.
    always_comb
    begin
        s_re_next = '0;
        s_im_next = '0;
        case (func_t'(func1_reg))
            FN_ADD:
            begin
                s_re_next = SUM_W'(a_re1_reg) + SUM_W'(b_re1_reg);
                s_im_next = SUM_W'(a_im1_reg) + SUM_W'(b_im1_reg);
            end
            FN_SUB:
            begin
                s_re_next = SUM_W'(a_re1_reg) - SUM_W'(b_re1_reg);
                s_im_next = SUM_W'(a_im1_reg) - SUM_W'(b_im1_reg);
            end
            FN_CONJ:
            begin
                s_re_next = SUM_W'(a_re1_reg);
                s_im_next = SUM_W'(0) - SUM_W'(a_im1_reg);
            end
            default:
            begin
                s_re_next = '0;
                s_im_next = '0;
            end
        endcase
    end

    // Stage 2: sums of products and the divisor.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            func2_reg <= func1_reg;
            eq2_reg   <= eq1_reg;
            gt2_reg   <= gt1_reg;
            m_re_reg  <= MAG_W'(p_rr_reg) - MAG_W'(p_ii_reg);
            m_im_reg  <= MAG_W'(p_ri_reg) + MAG_W'(p_ir_reg);
            n_re_reg  <= MAG_W'(p_rr_reg) + MAG_W'(p_ii_reg);
            n_im_reg  <= MAG_W'(p_ir_reg) - MAG_W'(p_ri_reg);
            den_reg   <= DEN_W'($unsigned(p_br_reg)) + DEN_W'($unsigned(p_bi_reg));
            s_re_reg  <= s_re_next;
            s_im_reg  <= s_im_next;
        end
    end

    // Stage 3: finish the simple operations and set up the long division.
    always_comb
    begin
        sat_t             r_re;
        sat_t             r_im;
        logic [REM_W-1:0] den_w;
        st3_next = '0;
        r_re     = '0;
        r_im     = '0;
        den_w    = REM_W'(den_reg);
        if (func_t'(func2_reg) == FN_MUL)
        begin
            r_re = saturate(m_re_reg[MAG_W-1], abs_mag(m_re_reg) >> FRAC_BITS);
            r_im = saturate(m_im_reg[MAG_W-1], abs_mag(m_im_reg) >> FRAC_BITS);
        end
        else
        begin
            r_re = saturate(s_re_reg[SUM_W-1], abs_mag(MAG_W'(s_re_reg)));
            r_im = saturate(s_im_reg[SUM_W-1], abs_mag(MAG_W'(s_im_reg)));
        end
        st3_next.is_div  = (func_t'(func2_reg) == FN_DIV);
        st3_next.dz      = (func_t'(func2_reg) == FN_DIV) && (den_reg == '0);
        st3_next.eq      = eq2_reg;
        st3_next.gt      = gt2_reg;
        st3_next.pre_ovf = r_re.ovf | r_im.ovf;
        st3_next.pre_re  = r_re.val;
        st3_next.pre_im  = r_im.val;
        st3_next.neg_re  = n_re_reg[MAG_W-1];
        st3_next.neg_im  = n_im_reg[MAG_W-1];
        st3_next.rem_re  = REM_W'(abs_mag(n_re_reg)) << FRAC_BITS;
        st3_next.rem_im  = REM_W'(abs_mag(n_im_reg)) << FRAC_BITS;
        // A quotient of 2^DATA_WIDTH or more always saturates.
        st3_next.big_re  = (st3_next.rem_re >= (den_w << DATA_WIDTH));
        st3_next.big_im  = (st3_next.rem_im >= (den_w << DATA_WIDTH));
        st3_next.dvs     = den_w << (DATA_WIDTH - 1);
        st3_next.q_re    = '0;
        st3_next.q_im    = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st3_reg <= st3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = st3_reg;

endmodule

// ===== hw/rtl/cau_div_stage.sv =====
// One restoring division step: produces one quotient bit of both result parts.
// Depends on cau_pkg; chained DATA_WIDTH times in the top level.
`timescale 1ns / 1ps

module cau_div_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  cau_pkg::stage_t in_data,
    output logic            out_valid,
    output cau_pkg::stage_t out_data
);
    import cau_pkg::*;

    logic   valid_reg;
    stage_t data_reg;
    stage_t data_next;

    // Trial subtraction of the shifted divisor from each remainder.
    always_comb
    begin
        logic bit_re;
        logic bit_im;
        data_next = in_data;
        bit_re    = (in_data.rem_re >= in_data.dvs);
        bit_im    = (in_data.rem_im >= in_data.dvs);
        if (bit_re)
        begin
            data_next.rem_re = in_data.rem_re - in_data.dvs;
        end
        if (bit_im)
        begin
            data_next.rem_im = in_data.rem_im - in_data.dvs;
        end
        data_next.q_re = {in_data.q_re[DATA_WIDTH-2:0], bit_re};
        data_next.q_im = {in_data.q_im[DATA_WIDTH-2:0], bit_im};
        data_next.dvs  = in_data.dvs >> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking bench of the complex arithmetic unit: a directed table, then random items,
// each result checked against a bit-exact predictor built on wide signed arithmetic.
// Depends on cau_pkg, cau_in_if, cau_out_if and complex_arithmetic_unit.
`timescale 1ns / 1ps

module tb_top;
    import cau_pkg::*;

    localparam int LATENCY  = DATA_WIDTH + 4;
    localparam int N_RANDOM = 1100;

    // One operation request and its expected response.
    typedef struct {
        logic [FUNC_W-1:0]            func;
        logic signed [DATA_WIDTH-1:0] a_re;
        logic signed [DATA_WIDTH-1:0] a_im;
        logic signed [DATA_WIDTH-1:0] b_re;
        logic signed [DATA_WIDTH-1:0] b_im;
    } op_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] re;
        logic signed [DATA_WIDTH-1:0] im;
        logic                         dz;
        logic                         ovf;
        logic                         eq;
        logic                         gt;
    } answer_t;

    // A directed row; known is set where the answer is typed in.
    typedef struct {
        op_t     op;
        logic    known;
        answer_t ans;
    } row_t;

    localparam logic signed [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic signed [DATA_WIDTH-1:0] ONE  = DATA_WIDTH'(1) << FRAC_BITS;

    logic clk;
    logic rst_n;
    int   errors;
    bit   stim_done;
    bit   hold_off;

    answer_t answers_due[$];

    cau_in_if  req ();
    cau_out_if rsp ();

    complex_arithmetic_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // Clock: 2 ns period.
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Clamp a wide signed value to the output word.
    function automatic logic signed [DATA_WIDTH-1:0] clamp(input logic signed [255:0] v,
                                                           inout logic ovf);
        if (v > 256'(signed'(MAXV)))
        begin
            ovf = 1'b1;
            return MAXV;
        end
        if (v < 256'(signed'(MINV)))
        begin
            ovf = 1'b1;
            return MINV;
        end
        return v[DATA_WIDTH-1:0];
    endfunction

    // Quotient truncated toward zero.
    function automatic logic signed [255:0] div_trunc(input logic signed [255:0] n,
                                                      input logic signed [255:0] d);
        logic [255:0] q;
        q = (n < 0 ? -n : n) / d;
        return (n < 0) ? -$signed(q) : $signed(q);
    endfunction

    // Shift right with truncation toward zero.
    function automatic logic signed [255:0] shr_trunc(input logic signed [255:0] v);
        logic [255:0] m;
        m = (v < 0 ? -v : v) >> FRAC_BITS;
        return (v < 0) ? -$signed(m) : $signed(m);
    endfunction

    // Bit-exact prediction of one complex operation.
    function automatic answer_t complex_result(input op_t op);
        answer_t r;
        logic signed [255:0] ar, ai, br, bi, re, im, den;
        ar = op.a_re; ai = op.a_im; br = op.b_re; bi = op.b_im;
        re = 0; im = 0;
        r.dz = 1'b0; r.ovf = 1'b0;
        case (op.func)
            FN_ADD:
            begin
                re = ar + br; im = ai + bi;
            end
            FN_SUB:
            begin
                re = ar - br; im = ai - bi;
            end
            FN_MUL:
            begin
                re = shr_trunc(ar * br - ai * bi);
                im = shr_trunc(ar * bi + ai * br);
            end
            FN_DIV:
            begin
                den = br * br + bi * bi;
                if (den == 0)
                    r.dz = 1'b1;
                else
                begin
                    re = div_trunc((ar * br + ai * bi) * (256'sd1 << FRAC_BITS), den);
                    im = div_trunc((ai * br - ar * bi) * (256'sd1 << FRAC_BITS), den);
                end
            end
            FN_CONJ:
            begin
                re = ar; im = -ai;
            end
            default: ;
        endcase
        r.re = clamp(re, r.ovf);
        r.im = clamp(im, r.ovf);
        r.eq = (op.a_re == op.b_re) && (op.a_im == op.b_im);
        r.gt = op.a_re > op.b_re;
        return r;
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] rand_word();
        case ($urandom_range(0, 7))
            0: return MAXV;
            1: return MINV;
            2: return 0;
            3: return DATA_WIDTH'($signed($urandom_range(0, 8 << FRAC_BITS))
                                  - $signed(4 << FRAC_BITS));
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [FUNC_W-1:0] rand_func();
        return ($urandom_range(0, 15) == 0) ? FUNC_W'($urandom_range(5, 7))
                                            : FUNC_W'($urandom_range(0, 4));
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        if ($urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(1, 3);
    endfunction

    // Offer one item and wait until it is accepted.
    task automatic send_item(input op_t op);
        int gap;
        gap = gap_len();
        repeat (gap)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.func  <= op.func;
        req.a_re  <= op.a_re;
        req.a_im  <= op.a_im;
        req.b_re  <= op.b_re;
        req.b_im  <= op.b_im;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        answers_due.push_back(complex_result(op));
    endtask

    // Stimulus: directed table, then random items.
    initial
    begin
        row_t rows[$];
        row_t rw;
        op_t  op;
        answer_t z;
        rst_n      = 1'b0;
        req.valid  = 1'b0;
        req.func   = '0;
        req.a_re   = '0;
        req.a_im   = '0;
        req.b_re   = '0;
        req.b_im   = '0;
        errors     = 0;
        stim_done  = 1'b0;
        hold_off   = 1'b0;
        z = '{re: 0, im: 0, dz: 0, ovf: 0, eq: 0, gt: 0};

        rw.known = 1'b1;
        rw.op = '{FN_ADD, 0, 0, 0, 0};       rw.ans = z; rw.ans.eq = 1; rows.push_back(rw);
        rw.op = '{FN_ADD, MAXV, MINV, ONE, MINV};
        rw.ans = '{MAXV, MINV, 0, 1, 0, 1};  rows.push_back(rw);
        rw.op = '{FN_SUB, MINV, MAXV, ONE, MINV};
        rw.ans = '{MINV, MAXV, 0, 1, 0, 0};  rows.push_back(rw);
        rw.op = '{FN_CONJ, ONE, MINV, ONE, MINV};
        rw.ans = '{ONE, MAXV, 0, 1, 1, 0};   rows.push_back(rw);
        rw.op = '{FN_DIV, ONE, ONE, 0, 0};
        rw.ans = z; rw.ans.dz = 1; rw.ans.gt = 1; rows.push_back(rw);
        rw.op = '{FN_DIV, MINV, MAXV, 0, 0};
        rw.ans = z; rw.ans.dz = 1; rows.push_back(rw);
        rw.op = '{FN_MUL, ONE, ONE, ONE, ONE};
        rw.ans = '{0, 2 * ONE, 0, 0, 1, 0};  rows.push_back(rw);
        rw.op = '{3'd5, MAXV, 0, MINV, 0};
        rw.ans = z; rw.ans.gt = 1; rows.push_back(rw);
        rw.op = '{3'd7, ONE, ONE, ONE, ONE};
        rw.ans = z; rw.ans.eq = 1; rows.push_back(rw);
        rw.known = 1'b0;
        rw.op = '{FN_MUL, MAXV, MAXV, MAXV, MINV};  rows.push_back(rw);
        rw.op = '{FN_MUL, MINV, MINV, MINV, MINV};  rows.push_back(rw);
        rw.op = '{FN_MUL, -ONE, 3, ONE / 2, -7};   rows.push_back(rw);
        rw.op = '{FN_DIV, MAXV, MINV, 1, 0};        rows.push_back(rw);
        rw.op = '{FN_DIV, MINV, MINV, MINV, MINV};  rows.push_back(rw);
        rw.op = '{FN_DIV, ONE, -ONE, 3 * ONE, ONE}; rows.push_back(rw);
        rw.op = '{FN_DIV, -5, 7, 0, -1};            rows.push_back(rw);
        rw.op = '{FN_SUB, -1, 1, 1, -1};            rows.push_back(rw);
        rw.op = '{3'd6, -1, -1, -1, -1};            rows.push_back(rw);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows; typed answers cross-check the predictor itself.
        foreach (rows[i])
        begin
            if (rows[i].known && complex_result(rows[i].op) !== rows[i].ans)
            begin
                $display("%0t: table row %0d expected %p predicted %p", $time, i,
                         rows[i].ans, complex_result(rows[i].op));
                errors++;
            end
            send_item(rows[i].op);
        end

        // Random items; a long receiver hold-off partway fills the pipeline.
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == N_RANDOM / 2)
                hold_off = 1'b1;
            op.func = rand_func();
            op.a_re = rand_word();
            op.a_im = rand_word();
            if ($urandom_range(0, 9) == 0)
            begin
                op.b_re = op.a_re;
                op.b_im = op.a_im;
            end
            else
            begin
                op.b_re = ($urandom_range(0, 9) == 0) ? 0 : rand_word();
                op.b_im = ($urandom_range(0, 9) == 0) ? 0 : rand_word();
            end
            send_item(op);
        end
        req.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Response side: random stalls, one long stall on request.
    initial
    begin
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                hold_off = 1'b0;
                rsp.ready <= 1'b0;
                repeat (200) @(posedge clk);
            end
            if ($urandom_range(0, 29) == 0)
            begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(10, 40)) @(posedge clk);
                rsp.ready <= 1'b1;
            end
            else
            begin
                rsp.ready <= ($urandom_range(0, 2) != 0) || ($urandom_range(0, 29) == 0);
            end
            @(posedge clk);
        end
    end

    // Compare each accepted item with the oldest expectation.
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (answers_due.size() == 0)
            begin
                $display("%0t: unexpected item re=%h im=%h", $time, rsp.res_re, rsp.res_im);
                errors++;
            end
            else
            begin
                want = answers_due.pop_front();
                if (rsp.res_re !== want.re || rsp.res_im !== want.im ||
                    rsp.div_zero !== want.dz || rsp.overflow !== want.ovf ||
                    rsp.equal !== want.eq || rsp.real_greater !== want.gt)
                begin
                    $display("%0t: expected re=%h im=%h dz=%b ovf=%b eq=%b gt=%b", $time,
                             want.re, want.im, want.dz, want.ovf, want.eq, want.gt);
                    $display("%0t: actual   re=%h im=%h dz=%b ovf=%b eq=%b gt=%b", $time,
                             rsp.res_re, rsp.res_im, rsp.div_zero, rsp.overflow,
                             rsp.equal, rsp.real_greater);
                    errors++;
                end
            end
        end
    end

    // End of run: drain, then allow for stray items.
    initial
    begin
        wait (stim_done);
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (2 * LATENCY) @(posedge clk);
        if (errors == 0 && answers_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Timeout.
    initial
    begin
        #400000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/cau_pkg.sv
hw/rtl/cau_in_if.sv
hw/rtl/cau_out_if.sv
hw/rtl/cau_front.sv
hw/rtl/cau_div_stage.sv
hw/rtl/complex_arithmetic_unit.sv
tb/sv/tb_top.sv
